// ----- hw/rtl/twr_pkg.sv -----
// Shared types, widths and codes for the time-weighted resampler.
// No dependencies; every other file refers to this package by scoped name.

package twr_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned IVL_W      = 20;
	localparam int unsigned ACC_W      = 64;
	localparam int unsigned DUR_W      = TIME_W + 1;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned GAP_LIMIT_DEF = 62;

	// iterations of the bit-serial unit
	localparam int unsigned MUL_STEPS  = DUR_W;
	localparam int unsigned DIV_STEPS  = ACC_W;
	localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

	localparam logic [TIME_W-1:0] WSTART_RESET = '0;
	localparam logic [IVL_W-1:0]  IVL_RESET    = IVL_W'(60);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LENGTH = CFG_IDX_W'(1);

	// slot kinds
	localparam logic [KIND_W-1:0] KIND_AVG = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_MIN = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_MAX = KIND_W'(2);

	typedef struct packed {
		logic [TIME_W-1:0]       sample_time;
		logic signed [VAL_W-1:0] sample_value;
		logic                    final_sample;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]       slot_time;
		logic signed [VAL_W-1:0] slot_value;
		logic [KIND_W-1:0]       slot_kind;
		logic                    last_slot;
		logic                    gap_error;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] window_start;
		logic [IVL_W-1:0]  interval;
	} cfg_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef struct packed {
		logic done;
	} arith_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DECIDE,
		ST_FIRST_WAIT,
		ST_GAP_WAIT,
		ST_ACC_GO,
		ST_ACC_WAIT,
		ST_CLOSE_MUL,
		ST_CLOSE_MUL_WAIT,
		ST_CLOSE_DIV_WAIT,
		ST_PUSH,
		ST_FINAL_EMIT
	} seq_state_t;

endpackage

// ----- hw/rtl/twr_arith.sv -----
// Shared bit-serial arithmetic unit: shift-add multiply-accumulate and
// restoring divide of a 64-bit magnitude by a 20-bit divisor. Uses twr_pkg.

module twr_arith (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  twr_pkg::arith_req_t                  req,
	input  logic [twr_pkg::ACC_W-1:0]            opa,
	input  logic [twr_pkg::DUR_W-1:0]            opb,
	input  logic [twr_pkg::ACC_W-1:0]            addend,
	output twr_pkg::arith_sts_t                  sts,
	output logic [twr_pkg::ACC_W-1:0]            result,
	output logic [twr_pkg::IVL_W-1:0]            remainder,
	output logic                                 neg
);

	logic                              busy_q;
	logic                              done_q;
	logic [twr_pkg::STEP_CNT_W-1:0]    cnt_q;
	twr_pkg::arith_op_t                op_q;
	logic [twr_pkg::ACC_W-1:0]         sh_q;
	logic [twr_pkg::DUR_W-1:0]         mb_q;
	logic [twr_pkg::ACC_W-1:0]         acc_q;
	logic [twr_pkg::IVL_W-1:0]         rem_q;
	logic                              neg_q;

	logic [twr_pkg::IVL_W:0]           rem_sh;
	logic [twr_pkg::IVL_W:0]           rem_sub;
	logic                              fits;

	assign rem_sh  = {rem_q, sh_q[twr_pkg::ACC_W-1]};
	assign fits    = rem_sh >= {1'b0, mb_q[twr_pkg::IVL_W-1:0]};
	assign rem_sub = rem_sh - {1'b0, mb_q[twr_pkg::IVL_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				if (req.op == twr_pkg::OP_MUL) begin
					cnt_q <= twr_pkg::STEP_CNT_W'(twr_pkg::MUL_STEPS - 1);
				end else begin
					cnt_q <= twr_pkg::STEP_CNT_W'(twr_pkg::DIV_STEPS - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			mb_q <= opb;
			rem_q <= '0;
			if (req.op == twr_pkg::OP_MUL) begin
				sh_q  <= opa;
				acc_q <= addend;
			end else begin
				// divide works on the magnitude, sign kept aside
				neg_q <= opa[twr_pkg::ACC_W-1];
				sh_q  <= opa[twr_pkg::ACC_W-1] ? (~opa + 1'b1) : opa;
			end
		end else if (busy_q) begin
			if (op_q == twr_pkg::OP_MUL) begin
				if (mb_q[0]) begin
					acc_q <= acc_q + sh_q;
				end
				sh_q <= {sh_q[twr_pkg::ACC_W-2:0], 1'b0};
				mb_q <= {1'b0, mb_q[twr_pkg::DUR_W-1:1]};
			end else begin
				rem_q <= fits ? rem_sub[twr_pkg::IVL_W-1:0] : rem_sh[twr_pkg::IVL_W-1:0];
				sh_q  <= {sh_q[twr_pkg::ACC_W-2:0], fits};
			end
		end
	end

	assign sts.done  = done_q;
	assign result    = (op_q == twr_pkg::OP_MUL) ? acc_q : sh_q;
	assign remainder = rem_q;
	assign neg       = neg_q;

endmodule

// ----- hw/rtl/twr_seq.sv -----
// Sequencer and series state: slot grid, weighted sum, min/max, pending slot,
// extremum choice and the output register. Drives twr_arith; uses twr_pkg.

module twr_seq #(
	parameter int unsigned GAP_LIMIT = twr_pkg::GAP_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  twr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output twr_pkg::out_item_t            out_data,
	input  twr_pkg::cfg_t                 cfg,
	output twr_pkg::arith_req_t           req,
	output logic [twr_pkg::ACC_W-1:0]     opa,
	output logic [twr_pkg::DUR_W-1:0]     opb,
	output logic [twr_pkg::ACC_W-1:0]     addend,
	input  twr_pkg::arith_sts_t           sts,
	input  logic [twr_pkg::ACC_W-1:0]     result,
	input  logic [twr_pkg::IVL_W-1:0]     remainder,
	input  logic                          neg
);

	localparam int unsigned CNT_W = $clog2(GAP_LIMIT + 1);
	localparam int unsigned TW    = twr_pkg::TIME_W;
	localparam int unsigned VW    = twr_pkg::VAL_W;

	twr_pkg::seq_state_t      state_q, state_d;
	twr_pkg::in_item_t        item_q;
	logic [TW-1:0]            tc_q;
	logic [TW-1:0]            sb_q;
	logic [TW-1:0]            last_q;
	logic [twr_pkg::ACC_W-1:0] wt_q;
	logic signed [VW-1:0]     held_q;
	logic signed [VW-1:0]     smin_q;
	logic signed [VW-1:0]     smax_q;
	logic                     seen_q;
	logic [1:0]               avs_q;
	logic signed [VW-1:0]     prev_q;
	logic [TW-1:0]            ptime_q;
	logic signed [VW-1:0]     pmin_q;
	logic signed [VW-1:0]     pmax_q;
	logic signed [VW-1:0]     pavg_q;
	logic signed [VW-1:0]     avg_q;
	logic                     gap_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [TW-1:0]            gap_base_q;
	logic                     fin_close_q;
	logic                     out_valid_q;
	twr_pkg::out_item_t       out_q;

	logic [TW:0]              slot_end;
	logic [TW:0]              dur_close;
	logic [twr_pkg::ACC_W-1:0] held_ext;
	logic [TW-1:0]            tc_raw;
	logic                     crosses;
	logic                     gap_now;
	logic                     q_big;
	logic signed [VW-1:0]     avg_sat;
	logic signed [VW-1:0]     pick_val;
	logic [twr_pkg::KIND_W-1:0] pick_kind;
	logic                     out_free;
	logic                     out_load;
	twr_pkg::out_item_t       out_next;
	logic                     push_go;
	logic                     loop_done;

	assign slot_end  = {1'b0, sb_q} + {{(TW + 1 - twr_pkg::IVL_W){1'b0}}, cfg.interval};
	assign dur_close = (slot_end > {1'b0, last_q}) ? (slot_end - {1'b0, last_q}) : '0;
	assign held_ext  = {{(twr_pkg::ACC_W - VW){held_q[VW-1]}}, held_q};
	assign crosses   = {1'b0, tc_q} >= slot_end;

	always_comb begin
		if (seen_q) begin
			tc_raw = (item_q.sample_time < last_q) ? last_q : item_q.sample_time;
		end else begin
			tc_raw = (item_q.sample_time < cfg.window_start) ? cfg.window_start
				: item_q.sample_time;
		end
	end

	assign gap_now = result > twr_pkg::ACC_W'(GAP_LIMIT);

	// quotient saturated to the signed 32-bit range
	assign q_big = |result[twr_pkg::ACC_W-1:VW-1];
	always_comb begin
		if (neg) begin
			avg_sat = q_big ? {1'b1, {(VW - 1){1'b0}}} : -$signed(result[VW-1:0]);
		end else begin
			avg_sat = q_big ? {1'b0, {(VW - 1){1'b1}}} : $signed(result[VW-1:0]);
		end
	end

	// pending slot against both neighbours
	always_comb begin
		pick_val  = pavg_q;
		pick_kind = twr_pkg::KIND_AVG;
		if (avs_q == 2'd2) begin
			if (prev_q > pavg_q && pavg_q < avg_q) begin
				pick_val  = pmin_q;
				pick_kind = twr_pkg::KIND_MIN;
			end else if (prev_q < pavg_q && pavg_q > avg_q) begin
				pick_val  = pmax_q;
				pick_kind = twr_pkg::KIND_MAX;
			end
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign push_go   = (state_q == twr_pkg::ST_PUSH) && (avs_q == 2'd0 || out_free);
	assign loop_done = cnt_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		req.start = 1'b0;
		req.op    = twr_pkg::OP_MUL;
		opa       = held_ext;
		opb       = dur_close;
		addend    = wt_q;
		out_load  = 1'b0;
		out_next.slot_time  = ptime_q;
		out_next.slot_value = pick_val;
		out_next.slot_kind  = pick_kind;
		out_next.last_slot  = 1'b0;
		out_next.gap_error  = gap_q;
		case (state_q)
			twr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = twr_pkg::ST_LOAD;
				end
			end
			twr_pkg::ST_LOAD: begin
				state_d = twr_pkg::ST_DECIDE;
			end
			twr_pkg::ST_DECIDE: begin
				opb = {{(twr_pkg::DUR_W - twr_pkg::IVL_W){1'b0}}, cfg.interval};
				if (!seen_q) begin
					req.start = 1'b1;
					req.op    = twr_pkg::OP_DIV;
					opa       = {{(twr_pkg::ACC_W - TW){1'b0}}, tc_q - cfg.window_start};
					state_d   = twr_pkg::ST_FIRST_WAIT;
				end else if (crosses) begin
					req.start = 1'b1;
					req.op    = twr_pkg::OP_DIV;
					opa       = {{(twr_pkg::ACC_W - TW){1'b0}}, tc_q - sb_q};
					state_d   = twr_pkg::ST_GAP_WAIT;
				end else begin
					state_d = twr_pkg::ST_ACC_GO;
				end
			end
			twr_pkg::ST_FIRST_WAIT: begin
				if (sts.done) begin
					state_d = twr_pkg::ST_ACC_GO;
				end
			end
			twr_pkg::ST_GAP_WAIT: begin
				if (sts.done) begin
					state_d = twr_pkg::ST_CLOSE_MUL;
				end
			end
			twr_pkg::ST_ACC_GO: begin
				req.start = 1'b1;
				opb       = {1'b0, tc_q - last_q};
				state_d   = twr_pkg::ST_ACC_WAIT;
			end
			twr_pkg::ST_ACC_WAIT: begin
				if (sts.done) begin
					state_d = item_q.final_sample ? twr_pkg::ST_CLOSE_MUL : twr_pkg::ST_IDLE;
				end
			end
			twr_pkg::ST_CLOSE_MUL: begin
				req.start = 1'b1;
				state_d   = twr_pkg::ST_CLOSE_MUL_WAIT;
			end
			twr_pkg::ST_CLOSE_MUL_WAIT: begin
				if (sts.done) begin
					req.start = 1'b1;
					req.op    = twr_pkg::OP_DIV;
					opa       = result;
					opb       = {{(twr_pkg::DUR_W - twr_pkg::IVL_W){1'b0}}, cfg.interval};
					state_d   = twr_pkg::ST_CLOSE_DIV_WAIT;
				end
			end
			twr_pkg::ST_CLOSE_DIV_WAIT: begin
				if (sts.done) begin
					state_d = twr_pkg::ST_PUSH;
				end
			end
			twr_pkg::ST_PUSH: begin
				if (push_go) begin
					out_load = avs_q != 2'd0;
					if (fin_close_q) begin
						state_d = twr_pkg::ST_FINAL_EMIT;
					end else if (loop_done) begin
						state_d = twr_pkg::ST_ACC_GO;
					end else begin
						state_d = twr_pkg::ST_CLOSE_MUL;
					end
				end
			end
			twr_pkg::ST_FINAL_EMIT: begin
				out_next.slot_value = pavg_q;
				out_next.slot_kind  = twr_pkg::KIND_AVG;
				out_next.last_slot  = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = twr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = twr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q        <= '0;
			last_q      <= '0;
			wt_q        <= '0;
			held_q      <= '0;
			smin_q      <= '0;
			smax_q      <= '0;
			seen_q      <= 1'b0;
			avs_q       <= '0;
			prev_q      <= '0;
			ptime_q     <= '0;
			pmin_q      <= '0;
			pmax_q      <= '0;
			pavg_q      <= '0;
			gap_q       <= 1'b0;
			cnt_q       <= '0;
			fin_close_q <= 1'b0;
		end else begin
			case (state_q)
				twr_pkg::ST_LOAD: begin
					gap_q       <= 1'b0;
					fin_close_q <= 1'b0;
				end
				twr_pkg::ST_FIRST_WAIT: begin
					if (sts.done) begin
						// grid starts at the slot holding the first sample
						sb_q   <= tc_q - {{(TW - twr_pkg::IVL_W){1'b0}}, remainder};
						last_q <= tc_q - {{(TW - twr_pkg::IVL_W){1'b0}}, remainder};
						wt_q   <= '0;
						held_q <= item_q.sample_value;
						smin_q <= item_q.sample_value;
						smax_q <= item_q.sample_value;
						seen_q <= 1'b1;
						avs_q  <= '0;
					end
				end
				twr_pkg::ST_GAP_WAIT: begin
					if (sts.done) begin
						gap_q <= gap_now;
						cnt_q <= gap_now ? CNT_W'(GAP_LIMIT) : result[CNT_W-1:0];
					end
				end
				twr_pkg::ST_ACC_WAIT: begin
					if (sts.done) begin
						wt_q   <= result;
						held_q <= item_q.sample_value;
						last_q <= tc_q;
						if (item_q.sample_value < smin_q) begin
							smin_q <= item_q.sample_value;
						end
						if (item_q.sample_value > smax_q) begin
							smax_q <= item_q.sample_value;
						end
						fin_close_q <= item_q.final_sample;
					end
				end
				twr_pkg::ST_CLOSE_MUL_WAIT: begin
					if (sts.done) begin
						wt_q <= result;
					end
				end
				twr_pkg::ST_PUSH: begin
					if (push_go) begin
						if (avs_q != 2'd0) begin
							prev_q <= pavg_q;
						end
						ptime_q <= sb_q;
						pmin_q  <= smin_q;
						pmax_q  <= smax_q;
						pavg_q  <= avg_q;
						if (avs_q != 2'd2) begin
							avs_q <= avs_q + 2'd1;
						end
						// skipped slots: jump the grid to the slot holding the sample
						if (!fin_close_q && loop_done && gap_q) begin
							sb_q   <= gap_base_q;
							last_q <= gap_base_q;
						end else begin
							sb_q   <= slot_end[TW-1:0];
							last_q <= slot_end[TW-1:0];
						end
						wt_q   <= '0;
						smin_q <= held_q;
						smax_q <= held_q;
						if (!fin_close_q) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				twr_pkg::ST_FINAL_EMIT: begin
					if (out_free) begin
						sb_q    <= '0;
						last_q  <= '0;
						wt_q    <= '0;
						held_q  <= '0;
						smin_q  <= '0;
						smax_q  <= '0;
						seen_q  <= 1'b0;
						avs_q   <= '0;
						prev_q  <= '0;
						ptime_q <= '0;
						pmin_q  <= '0;
						pmax_q  <= '0;
						pavg_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == twr_pkg::ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == twr_pkg::ST_LOAD) begin
			tc_q <= tc_raw;
		end
		if (state_q == twr_pkg::ST_GAP_WAIT && sts.done) begin
			gap_base_q <= tc_q - {{(TW - twr_pkg::IVL_W){1'b0}}, remainder};
		end
		if (state_q == twr_pkg::ST_CLOSE_DIV_WAIT && sts.done) begin
			avg_q <= avg_sat;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/time_weighted_resampler_top.sv -----
// Time-weighted resampler. One item at a time; in_ready only while idle.
// Per item: load, decide and a multiply-accumulate before ready returns, plus a divide
// on the first sample of a series and a divide when a sample crosses a slot end, plus
// per closed slot a 33-step multiply, a 64-step divide and a push, plus a final emit
// on a final sample. A full output register holds the sequencer until the beat is taken.
// Reset (arst_n, async, active low) clears the series and restores defaults.

module time_weighted_resampler_top #(
	parameter int unsigned GAP_LIMIT = twr_pkg::GAP_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  twr_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output twr_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [twr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [twr_pkg::TIME_W-1:0] window_start_q;
	logic [twr_pkg::IVL_W-1:0]  interval_q;
	twr_pkg::cfg_t              cfg;
	twr_pkg::arith_req_t        req;
	twr_pkg::arith_sts_t        sts;
	logic [twr_pkg::ACC_W-1:0]  opa;
	logic [twr_pkg::DUR_W-1:0]  opb;
	logic [twr_pkg::ACC_W-1:0]  addend;
	logic [twr_pkg::ACC_W-1:0]  result;
	logic [twr_pkg::IVL_W-1:0]  remainder;
	logic                       neg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= twr_pkg::WSTART_RESET;
			interval_q     <= twr_pkg::IVL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				twr_pkg::REG_WINDOW_START: begin
					window_start_q <= cfg_data[twr_pkg::TIME_W-1:0];
				end
				twr_pkg::REG_INTERVAL_LENGTH: begin
					interval_q <= cfg_data[twr_pkg::IVL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero length counts as one second
	assign cfg.window_start = window_start_q;
	assign cfg.interval     = (interval_q == '0) ? twr_pkg::IVL_W'(1) : interval_q;

	twr_seq #(
		.GAP_LIMIT(GAP_LIMIT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg      (cfg),
		.req      (req),
		.opa      (opa),
		.opb      (opb),
		.addend   (addend),
		.sts      (sts),
		.result   (result),
		.remainder(remainder),
		.neg      (neg)
	);

	twr_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.opa      (opa),
		.opb      (opb),
		.addend   (addend),
		.sts      (sts),
		.result   (result),
		.remainder(remainder),
		.neg      (neg)
	);

endmodule

// ----- hw/rtl/twr_checker.sv -----
// Port-level checks for the resampler top, attached by bind.
// Uses twr_pkg for payload types and slot kind codes.

module twr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input twr_pkg::out_item_t out_data
);

	// a result beat waits unchanged until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed while stalled");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.slot_kind == twr_pkg::KIND_AVG ||
			out_data.slot_kind == twr_pkg::KIND_MIN ||
			out_data.slot_kind == twr_pkg::KIND_MAX)
		else $error("unknown slot kind");

	// the final slot of a series always gives its average
	a_last_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_slot |-> out_data.slot_kind == twr_pkg::KIND_AVG)
		else $error("final slot not an average");

	// one sample at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in progress");

endmodule

bind time_weighted_resampler_top twr_checker u_twr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ----- tb/time_weighted_resampler_top_tb.sv -----
// Self-checking testbench for time_weighted_resampler_top: directed, backpressure and
// random series of samples, checked beat by beat against an in-bench slot predictor.
// Depends on twr_pkg and the resampler RTL only.

module time_weighted_resampler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GAP_SLOTS = twr_pkg::GAP_LIMIT_DEF;
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam longint unsigned CYCLE_LIMIT = 12_000_000;
	localparam int unsigned RANDOM_ITEMS = 300;
	localparam logic [twr_pkg::CFG_IDX_W-1:0] REG_SPARE = twr_pkg::CFG_IDX_W'(3);
	localparam logic signed [twr_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [twr_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	twr_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	twr_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [twr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [twr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	time_weighted_resampler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// slot predictor state
	logic [twr_pkg::TIME_W-1:0] grid_start;
	logic [twr_pkg::IVL_W-1:0] slot_len;
	logic [twr_pkg::TIME_W-1:0] cur_slot, chg_time, pend_time;
	logic [twr_pkg::ACC_W-1:0] area;
	logic signed [twr_pkg::VAL_W-1:0] held, lo, hi, prev_avg, pend_lo, pend_hi, pend_avg;
	logic live;
	int unsigned avgs_known;
	logic gap_hit;
	twr_pkg::out_item_t slots_due[$];

	int unsigned faults = 0;
	longint unsigned cycles = 0;
	logic steady_send = 1'b0;
	int unsigned burst_left = 0;
	logic hold_off_req = 1'b0;
	int unsigned hold_off_len = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] eff_len();
		return (slot_len == '0) ? 32'd1 : {12'd0, slot_len};
	endfunction

	function automatic logic [twr_pkg::ACC_W-1:0] value_seconds(
			input logic signed [twr_pkg::VAL_W-1:0] v,
			input logic [twr_pkg::ACC_W-1:0] d);
		logic [twr_pkg::ACC_W-1:0] wide;
		wide = {{32{v[31]}}, v};
		return wide * d;
	endfunction

	// truncating divide, saturated to 32 bits signed
	function automatic logic signed [twr_pkg::VAL_W-1:0] mean_of(
			input logic [twr_pkg::ACC_W-1:0] sum,
			input logic [31:0] len);
		logic [twr_pkg::ACC_W-1:0] mag, q;
		mag = sum[twr_pkg::ACC_W-1] ? -sum : sum;
		q = mag / {32'd0, len};
		if (sum[twr_pkg::ACC_W-1])
			return (q >= 64'h8000_0000) ? VAL_MIN : -$signed(q[31:0]);
		return (q > 64'h7FFF_FFFF) ? VAL_MAX : $signed(q[31:0]);
	endfunction

	function automatic void post_slot(input logic [31:0] t, input logic signed [31:0] v,
			input logic [twr_pkg::KIND_W-1:0] kind, input logic last);
		twr_pkg::out_item_t s;
		s.slot_time = t;
		s.slot_value = v;
		s.slot_kind = kind;
		s.last_slot = last;
		s.gap_error = gap_hit;
		slots_due.push_back(s);
	endfunction

	// a slot goes out one slot late, once its right neighbour's average is known
	function automatic void retire_slot(input logic [31:0] t,
			input logic signed [twr_pkg::VAL_W-1:0] mn, mx, avg);
		if (avgs_known == 1) begin
			post_slot(pend_time, pend_avg, twr_pkg::KIND_AVG, 1'b0);
		end else if (avgs_known >= 2) begin
			if (prev_avg > pend_avg && pend_avg < avg)
				post_slot(pend_time, pend_lo, twr_pkg::KIND_MIN, 1'b0);
			else if (prev_avg < pend_avg && pend_avg > avg)
				post_slot(pend_time, pend_hi, twr_pkg::KIND_MAX, 1'b0);
			else
				post_slot(pend_time, pend_avg, twr_pkg::KIND_AVG, 1'b0);
		end
		if (avgs_known >= 1)
			prev_avg = pend_avg;
		pend_time = t;
		pend_lo = mn;
		pend_hi = mx;
		pend_avg = avg;
		if (avgs_known < 2)
			avgs_known++;
	endfunction

	function automatic void seal_slot();
		logic [twr_pkg::ACC_W-1:0] slot_end, dur;
		logic [31:0] len;
		len = eff_len();
		slot_end = {32'd0, cur_slot} + {32'd0, len};
		dur = (slot_end > {32'd0, chg_time}) ? slot_end - {32'd0, chg_time} : '0;
		area = area + value_seconds(held, dur);
		retire_slot(cur_slot, lo, hi, mean_of(area, len));
		cur_slot = slot_end[31:0];
		chg_time = cur_slot;
		area = '0;
		lo = held;
		hi = held;
	endfunction

	function automatic void drop_series();
		cur_slot = '0;
		chg_time = '0;
		area = '0;
		held = '0;
		lo = '0;
		hi = '0;
		live = 1'b0;
		avgs_known = 0;
		prev_avg = '0;
		pend_time = '0;
		pend_lo = '0;
		pend_hi = '0;
		pend_avg = '0;
	endfunction

	function automatic void take_sample(input twr_pkg::in_item_t beat);
		logic [31:0] t, len, base, dt;
		logic signed [31:0] v;
		logic [63:0] n, cnt, wide, k;
		t = beat.sample_time;
		v = beat.sample_value;
		len = eff_len();
		gap_hit = 1'b0;
		if (!live) begin
			if (t < grid_start)
				t = grid_start;
			n = {32'd0, t - grid_start} / {32'd0, len};
			wide = {32'd0, grid_start} + n * {32'd0, len};
			cur_slot = wide[31:0];
			chg_time = cur_slot;
			area = '0;
			held = v;
			lo = v;
			hi = v;
			live = 1'b1;
			avgs_known = 0;
		end else begin
			if (t < chg_time)
				t = chg_time;
			if ({32'd0, t} >= {32'd0, cur_slot} + {32'd0, len}) begin
				base = cur_slot;
				n = {32'd0, t - cur_slot} / {32'd0, len};
				cnt = (n > GAP_SLOTS) ? 64'(GAP_SLOTS) : n;
				gap_hit = (n > GAP_SLOTS);
				for (k = 0; k < cnt; k++)
					seal_slot();
				if (gap_hit) begin
					// slots past the limit are skipped, grid jumps to the sample
					wide = {32'd0, base} + n * {32'd0, len};
					cur_slot = wide[31:0];
					chg_time = cur_slot;
					area = '0;
					lo = held;
					hi = held;
				end
			end
		end
		dt = t - chg_time;
		area = area + value_seconds(held, {32'd0, dt});
		held = v;
		chg_time = t;
		if (v < lo)
			lo = v;
		if (v > hi)
			hi = v;
		if (beat.final_sample) begin
			seal_slot();
			if (avgs_known >= 1)
				post_slot(pend_time, pend_avg, twr_pkg::KIND_AVG, 1'b1);
			drop_series();
		end
	endfunction

	task automatic check_slot(input twr_pkg::out_item_t got);
		twr_pkg::out_item_t want;
		if (slots_due.size() == 0) begin
			$error("slot at %0d (value %0d) arrived with nothing expected",
				got.slot_time, got.slot_value);
			faults++;
		end else begin
			want = slots_due.pop_front();
			if (got.slot_time !== want.slot_time) begin
				$error("slot_time expected %0d got %0d", want.slot_time, got.slot_time);
				faults++;
			end
			if (got.slot_value !== want.slot_value) begin
				$error("slot_value expected %0d got %0d", want.slot_value, got.slot_value);
				faults++;
			end
			if (got.slot_kind !== want.slot_kind) begin
				$error("slot_kind expected %0d got %0d", want.slot_kind, got.slot_kind);
				faults++;
			end
			if (got.last_slot !== want.last_slot) begin
				$error("last_slot expected %0b got %0b", want.last_slot, got.last_slot);
				faults++;
			end
			if (got.gap_error !== want.gap_error) begin
				$error("gap_error expected %0b got %0b", want.gap_error, got.gap_error);
				faults++;
			end
		end
	endtask

	// results first: they belong to beats taken earlier
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_slot(out_data);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == twr_pkg::REG_WINDOW_START)
					grid_start = cfg_data;
				else if (cfg_index == twr_pkg::REG_INTERVAL_LENGTH)
					slot_len = cfg_data[twr_pkg::IVL_W-1:0];
			end
			if (in_valid && in_ready)
				take_sample(in_data);
		end
	end

	// sink pacing: ready runs, short stalls, calm stretches, and the long hold-off on request
	initial begin : sink_pacing
		int unsigned ready_run, stall_run, calm;
		ready_run = 4;
		stall_run = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				out_ready <= 1'b1;
			end else if (calm > 0) begin
				calm--;
				out_ready <= 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
				out_ready <= 1'b0;
			end else if (ready_run > 0) begin
				ready_run--;
				out_ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 9) == 0)
					calm = $urandom_range(50, 300);
				ready_run = $urandom_range(1, 12);
				stall_run = $urandom_range(0, 9);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic reset_block();
		grid_start = twr_pkg::WSTART_RESET;
		slot_len = twr_pkg::IVL_RESET;
		drop_series();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// one sample beat; valid stays up into the next call unless a gap is due
	task automatic send_sample(input logic [31:0] t, input logic signed [31:0] v,
			input logic fin);
		twr_pkg::in_item_t beat;
		beat.sample_time = t;
		beat.sample_value = v;
		beat.final_sample = fin;
		in_data <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (!steady_send) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				burst_left = $urandom_range(0, 6);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic write_reg(input logic [twr_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected slot, then for any silent slot closing to finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (slots_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic test_single_flush();
		send_sample(32'd0, VAL_MAX, 1'b1);
		drain();
	endtask

	task automatic test_field_extremes();
		send_sample(32'd10, VAL_MIN, 1'b0);
		send_sample(32'd70, VAL_MAX, 1'b0);
		send_sample(32'd130, 32'sd0, 1'b0);
		send_sample(32'd50, -32'sd1, 1'b0);          // earlier than previous beat
		send_sample(32'd400, 32'sd1, 1'b0);          // empty slots in between
		send_sample(32'hFFFF_FFFF, 32'sh5555_AAAA, 1'b0);  // far past the gap limit
		send_sample(32'hFFFF_FFFF, 32'sh2AAA_5555, 1'b1);
		drain();
	endtask

	task automatic test_dip_and_peak();
		write_reg(twr_pkg::REG_WINDOW_START, 32'd5);
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd10);
		send_sample(32'd5, 32'sd100, 1'b0);
		send_sample(32'd15, 32'sd40, 1'b0);
		send_sample(32'd25, 32'sd100, 1'b0);
		send_sample(32'd35, 32'sd150, 1'b0);
		send_sample(32'd38, 32'sd170, 1'b0);
		send_sample(32'd45, 32'sd90, 1'b1);
		drain();
	endtask

	task automatic test_before_window();
		write_reg(twr_pkg::REG_WINDOW_START, 32'd1000);
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd7);
		send_sample(32'd3, 32'sh0001_0000, 1'b0);
		send_sample(32'd1020, 32'shFFFF_0000, 1'b0);
		send_sample(32'd1030, 32'sh0000_8000, 1'b1);
		drain();
	endtask

	task automatic test_interval_change();
		write_reg(twr_pkg::REG_WINDOW_START, 32'd0);
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd1000);
		send_sample(32'd0, VAL_MAX, 1'b0);
		send_sample(32'd999, VAL_MAX, 1'b0);
		drain();
		// shrink mid-series: slot ends fall behind the last change, average saturates
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd1);
		send_sample(32'd1005, 32'sd7, 1'b0);
		drain();
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd0);
		send_sample(32'd1010, 32'sd5, 1'b0);
		send_sample(32'd1012, -32'sd5, 1'b1);
		drain();
		write_reg(REG_SPARE, $urandom());
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'hFFFF_FFFF);
		write_reg(twr_pkg::REG_WINDOW_START, 32'h8000_0000);
		send_sample(32'h8000_0005, VAL_MIN, 1'b0);
		send_sample(32'h8000_0000 + 3 * 32'hF_FFFF + 1, VAL_MAX, 1'b0);
		send_sample(32'h8000_0000 + 4 * 32'hF_FFFF, 32'sd0, 1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		int unsigned i;
		write_reg(twr_pkg::REG_WINDOW_START, 32'd0);
		write_reg(twr_pkg::REG_INTERVAL_LENGTH, 32'd3);
		steady_send = 1'b1;
		hold_off_len = 2000;
		hold_off_req = 1'b1;
		for (i = 0; i < 12; i++)
			send_sample(6 * i + 1, (i % 2) ? 32'sd300 : -32'sd300, i == 11);
		drain();
		steady_send = 1'b0;
	endtask

	task automatic test_random_series();
		logic [31:0] ws, len_word, span, t, jitter;
		logic signed [31:0] v, level;
		int unsigned sent, n, i, pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				ws = 32'd0;
			else if (pick < 7)
				ws = $urandom();
			else if (pick == 7)
				ws = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			else
				ws = $urandom_range(0, 100000);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				len_word = $urandom_range(1, 10);
			else if (pick < 6)
				len_word = 32'd60;
			else if (pick == 6)
				len_word = $urandom_range(1, 20'hF_FFFF);
			else if (pick == 7)
				len_word = 32'h000F_FFFF;
			else if (pick == 8)
				len_word = 32'd0;
			else
				len_word = $urandom();
			span = (len_word[twr_pkg::IVL_W-1:0] == '0) ? 32'd1
				: {12'd0, len_word[twr_pkg::IVL_W-1:0]};
			steady_send = ($urandom_range(0, 4) == 0);
			write_reg(twr_pkg::REG_WINDOW_START, ws);
			write_reg(twr_pkg::REG_INTERVAL_LENGTH, len_word);

			pick = $urandom_range(0, 9);
			if (pick < 8)
				t = ws + $urandom_range(0, 3) * span + $urandom_range(0, 50);
			else if (pick == 8)
				t = $urandom();
			else
				t = ws - $urandom_range(1, 1000);
			level = $urandom();
			n = $urandom_range(1, 16);
			for (i = 0; i < n; i++) begin
				if (i != 0) begin
					if ($urandom_range(0, 32) == 0) begin
						// interval change within the series
						drain();
						len_word = $urandom_range(0, 99);
						span = (len_word == 32'd0) ? 32'd1 : len_word;
						write_reg(twr_pkg::REG_INTERVAL_LENGTH, len_word);
					end
					pick = $urandom_range(0, 99);
					if (pick < 40)
						t = t + $urandom_range(0, span - 1);
					else if (pick < 75)
						t = t + span * $urandom_range(1, 3) + $urandom_range(0, span - 1);
					else if (pick < 85)
						t = t + span * $urandom_range(4, 10);
					else if (pick < 91)
						t = t - $urandom_range(1, 50);
					else if (pick < 95)
						t = t + span * $urandom_range(63, 80);
					else if (pick < 97)
						t = $urandom();
				end
				pick = $urandom_range(0, 9);
				if ($urandom_range(0, 15) == 0)
					level = $urandom();
				jitter = $urandom_range(0, 4000);
				if (pick < 2)
					v = $urandom();
				else if (pick == 2)
					v = VAL_MAX;
				else if (pick == 3)
					v = VAL_MIN;
				else
					v = level + jitter - 32'd2000;
				send_sample(t, v, (i == n - 1) && ($urandom_range(0, 9) != 0));
				sent++;
			end
			drain();
		end
		steady_send = 1'b0;
	endtask

	initial begin
		reset_block();
		test_single_flush();
		test_field_extremes();
		test_dip_and_peak();
		test_before_window();
		test_interval_change();
		test_backpressure();
		test_random_series();
		drain();
		if (faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
